[rtl/npq_pkg.sv]
// Shared types, widths and helpers for the nearest palette color quantizer.
// No dependencies; imported by npq_cell and the top level.
`default_nettype none

package npq_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;

   localparam int IDX_W  = 8;   // palette index / slot width
   localparam int CNT_W  = 9;   // palette_count register width
   localparam int CH_W   = 8;   // one color channel
   localparam int RGB_W  = 24;  // packed R:G:B
   localparam int SQ_W   = 16;  // one squared channel difference
   localparam int DIST_W = 18;  // sum of three squares, max 195075

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_PIXEL = 1'b1
   } func_type;

   // One beat as it travels down the cell chain.
   typedef struct packed {
      func_type            func;
      logic [IDX_W-1:0]    slot;       // palette slot for a write
      logic [RGB_W-1:0]    rgb;        // pixel, or the entry being written
      logic [IDX_W-1:0]    best_idx;
      logic [DIST_W-1:0]   best_dist;
      logic                have;       // best_* holds a real candidate
   } item_type;

   // Beat between the square and the compare half of a cell.
   typedef struct packed {
      item_type            item;
      logic [SQ_W-1:0]     sq_r;
      logic [SQ_W-1:0]     sq_g;
      logic [SQ_W-1:0]     sq_b;
   } mid_type;

   function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      logic [CH_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return {{(SQ_W-CH_W){1'b0}}, d} * {{(SQ_W-CH_W){1'b0}}, d};
   endfunction

endpackage

`default_nettype wire

[rtl/npq_cell.sv]
// One systolic cell: holds one palette entry, squares the channel deltas,
// then sums and keeps the running best. Depends on npq_pkg.
`default_nettype none

module npq_cell
   import npq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic [IDX_W-1:0]   cell_index,
   input  wire logic [CNT_W-1:0]   palette_count,
   input  wire logic               in_valid,
   input  wire item_type           in_item,
   output logic                    out_valid,
   output item_type                out_item
);

   logic [RGB_W-1:0] entry_ff;
   logic             mid_valid_ff;
   mid_type          mid_ff;
   mid_type          mid_in;
   logic             out_valid_ff;
   item_type         out_ff;
   item_type         out_in;

   logic               wr_hit;
   logic [DIST_W-1:0]  cand_dist;
   logic               active;
   logic               take;

   // A write lands here as it passes, so later beats see it and earlier ones do not.
   assign wr_hit = en && in_valid && (in_item.func == FUNC_WRITE) &&
                   (in_item.slot == cell_index);

   always_comb begin
      mid_in.item = in_item;
      mid_in.sq_r = sq_diff(in_item.rgb[23:16], entry_ff[23:16]);
      mid_in.sq_g = sq_diff(in_item.rgb[15:8],  entry_ff[15:8]);
      mid_in.sq_b = sq_diff(in_item.rgb[7:0],   entry_ff[7:0]);
   end

   always_comb begin
      cand_dist = DIST_W'(mid_ff.sq_r) + DIST_W'(mid_ff.sq_g) + DIST_W'(mid_ff.sq_b);
      active    = {1'b0, cell_index} < palette_count;
      take      = (mid_ff.item.func == FUNC_PIXEL) && active &&
                  (!mid_ff.item.have || (cand_dist < mid_ff.item.best_dist));
      out_in    = mid_ff.item;
      if (take) begin
         out_in.best_idx  = cell_index;
         out_in.best_dist = cand_dist;
         out_in.have      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         entry_ff <= in_item.rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         mid_valid_ff <= in_valid;
         out_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff <= mid_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

`default_nettype wire

[rtl/nearest_palette_colour_quantizer.sv]
// Nearest palette color quantizer: input register, a chain of PALETTE_DEPTH
// npq_cell instances and a result register. Depends on npq_pkg and npq_cell.
//
// Usage:
//   req_* carries one beat: req_func = FUNC_WRITE stores {red,green,blue} into
//   slot req_entry_index (slots at or beyond PALETTE_DEPTH are dropped) and
//   gives no result; FUNC_PIXEL quantizes req_pixel_rgb and gives one rsp_
//   beat with the lowest index of the nearest entry below palette_count.
//   csr_* writes palette_count (csr_ready is always high); write it only
//   while the block is idle. A count of zero returns index 0.
//   Throughput: one beat per cycle unless rsp_stall holds the chain; each
//   cell owns one entry and one distance unit, split over two register stages
//   (square, then sum and compare). Reset clears all valid bits and
//   palette_count; palette entries stay undefined until written. While
//   rsp_valid is held by rsp_stall the whole chain freezes and req_stall is
//   raised, so nothing is lost or repeated.
`default_nettype none

module nearest_palette_colour_quantizer
   import npq_pkg::*;
#(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_func,
   input  wire logic [IDX_W-1:0]   req_entry_index,
   input  wire logic [CH_W-1:0]    req_entry_red,
   input  wire logic [CH_W-1:0]    req_entry_green,
   input  wire logic [CH_W-1:0]    req_entry_blue,
   input  wire logic [RGB_W-1:0]   req_pixel_rgb,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [IDX_W-1:0]        rsp_palette_index,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CNT_W-1:0]   csr_palette_count
);

   logic [CNT_W-1:0] count_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [IDX_W-1:0] rsp_index_ff;
   logic             en;
   item_type         front_in;
   logic             ch_valid [PALETTE_DEPTH+1];
   item_type         ch_item  [PALETTE_DEPTH+1];
   logic             front_valid_ff;
   item_type         front_ff;

   // Chain advances unless a finished result is being held.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_palette_count;
      end
   end

   always_comb begin
      front_in.func      = func_type'(req_func);
      front_in.slot      = req_entry_index;
      front_in.rgb       = (func_type'(req_func) == FUNC_WRITE) ?
                           {req_entry_red, req_entry_green, req_entry_blue} :
                           req_pixel_rgb;
      front_in.best_idx  = '0;
      front_in.best_dist = '0;
      front_in.have      = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (en) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign ch_valid[0] = front_valid_ff;
   assign ch_item[0]  = front_ff;

   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      npq_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .en            (en),
         .cell_index    (IDX_W'(k)),
         .palette_count (count_ff),
         .in_valid      (ch_valid[k]),
         .in_item       (ch_item[k]),
         .out_valid     (ch_valid[k+1]),
         .out_item      (ch_item[k+1])
      );
   end

   // Writes end their trip at the last cell; only pixels make a result.
   assign rsp_valid_in = ch_valid[PALETTE_DEPTH] &&
                         (ch_item[PALETTE_DEPTH].func == FUNC_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_index_ff <= ch_item[PALETTE_DEPTH].best_idx;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;

   a_index_in_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_palette_index} < CNT_W'(PALETTE_DEPTH)))
      else $error("result index beyond palette depth");

   a_no_candidate_zero: assert property (@(posedge clock) disable iff (reset)
      (ch_valid[PALETTE_DEPTH] && (ch_item[PALETTE_DEPTH].func == FUNC_PIXEL) &&
       !ch_item[PALETTE_DEPTH].have) |-> (ch_item[PALETTE_DEPTH].best_idx == '0))
      else $error("pixel without candidate carries nonzero index");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (en && ch_valid[PALETTE_DEPTH] &&
       (ch_item[PALETTE_DEPTH].func == FUNC_WRITE)) |=> !rsp_valid)
      else $error("palette write produced a result beat");

endmodule

`default_nettype wire
